@@ sv/mtc_pkg.sv @@
package mtc_pkg;

	localparam int MAX_MESSAGES   = 256;
	localparam int MAX_SUCCESSORS = 16;
	localparam int COUNT_BITS     = 16;

	// Widths that follow from the sizes above.
	localparam int POS_W  = $clog2(MAX_MESSAGES);
	localparam int MT_W   = $clog2(MAX_MESSAGES + 1);
	localparam int SLOT_W = (MAX_SUCCESSORS > 1) ? $clog2(MAX_SUCCESSORS) : 1;
	localparam int SI_W   = $clog2(MAX_SUCCESSORS + 1);
	localparam int SA_W   = $clog2(MAX_MESSAGES * MAX_SUCCESSORS);
	localparam int KEY_W  = 26;
	localparam int SUCC_W = POS_W + COUNT_BITS;

	typedef logic [KEY_W-1:0] key_t;

	typedef struct packed {
		logic [POS_W-1:0]      position;
		logic                  position_is_new;
		logic                  had_previous;
		logic [SLOT_W-1:0]     successor_slot;
		logic                  successor_is_new;
		logic [COUNT_BITS-1:0] transition_count;
		logic                  table_full;
		logic                  successors_full;
		logic                  count_saturated;
	} result_t;

endpackage

@@ sv/message_transition_counter.sv @@
// Counts transitions between successive MIDI messages.
// The input channel (in_valid / in_ready) takes one message beat: msg_length
// and up to three bytes; bytes beyond msg_length are treated as zero. A beat
// with msg_length of zero is absorbed with no result and no change of state.
// Every other beat gives exactly one result beat on the output channel
// (out_valid / out_ready), held in an output register.
// How long a message takes is set by the linear scans: the message table (up
// to 256 distinct messages) and the successor table (up to 16 successors per
// message) each have one read port and one comparator, and the scan looks at
// one entry per cycle. in_ready is high only while the sequencer is idle, so
// the block takes no new message until the sequencer has finished the last.
// If the receiver stalls, a finished result waits in the output register;
// the sequencer may take and work on the next message, and then holds in its
// result state until the register frees.
// Reset clears the message count, the previous-message marker and the
// per-message successor counts (a valid bit per message), so no clearing
// pass is needed and the block is ready as soon as reset is released.
module message_transition_counter (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [1:0]  msg_length,
	input  logic [7:0]  status_byte,
	input  logic [7:0]  data_one,
	input  logic [7:0]  data_two,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  position,
	output logic        position_is_new,
	output logic        had_previous,
	output logic [3:0]  successor_slot,
	output logic        successor_is_new,
	output logic [15:0] transition_count,
	output logic        table_full,
	output logic        successors_full,
	output logic        count_saturated
);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_MSCAN,
		ST_TOTRD,
		ST_TOTCHK,
		ST_SSCAN,
		ST_RESULT
	} state_t;

	state_t                            state_q;
	mtc_pkg::key_t                     key_q;
	logic [mtc_pkg::POS_W-1:0]         pos_q;
	logic [mtc_pkg::MT_W-1:0]          idx_q;
	logic                              pend_q;
	logic [mtc_pkg::POS_W-1:0]         pend_idx_q;
	logic [mtc_pkg::MT_W-1:0]          mtotal_q;
	logic                              prev_valid_q;
	logic [mtc_pkg::POS_W-1:0]         prev_pos_q;
	logic [mtc_pkg::SI_W-1:0]          stot_q;
	logic [mtc_pkg::SI_W-1:0]          sidx_q;
	logic                              spend_q;
	logic [mtc_pkg::SLOT_W-1:0]        spend_idx_q;
	logic [mtc_pkg::MAX_MESSAGES-1:0]  st_vld_q;
	mtc_pkg::result_t                  res_q;

	// Memory ports.
	logic                              msg_we;
	mtc_pkg::key_t                     msg_rdata;
	logic                              succ_we;
	logic [mtc_pkg::SA_W-1:0]          succ_base;
	logic [mtc_pkg::SA_W-1:0]          succ_waddr;
	logic [mtc_pkg::SA_W-1:0]          succ_raddr;
	logic [mtc_pkg::SUCC_W-1:0]        succ_wdata;
	logic [mtc_pkg::SUCC_W-1:0]        succ_rdata;
	logic                              tot_we;
	logic [mtc_pkg::SI_W-1:0]          tot_rdata;

	// Scan decisions and the shared count incrementer.
	logic                              msg_hit;
	logic                              msg_miss;
	logic                              msg_tab_full;
	logic                              succ_hit;
	logic                              succ_miss;
	logic                              succ_room;
	logic [mtc_pkg::COUNT_BITS-1:0]    cnt_cur;
	logic                              cnt_sat;
	logic [mtc_pkg::COUNT_BITS-1:0]    cnt_next;

	logic                              out_space;
	logic                              out_load;
	mtc_pkg::result_t                  res_out;

	assign in_ready = (state_q == ST_IDLE);

	// Message table scan: the read issued last cycle is compared this cycle.
	assign msg_hit      = pend_q && (msg_rdata == key_q);
	assign msg_miss     = !pend_q && (idx_q == mtotal_q);
	assign msg_tab_full = (mtotal_q == mtc_pkg::MT_W'(mtc_pkg::MAX_MESSAGES));
	assign msg_we       = (state_q == ST_MSCAN) && !msg_hit && msg_miss && !msg_tab_full;

	// Successor list of the previous message sits in one row of the table.
	assign succ_base  = mtc_pkg::SA_W'(32'(prev_pos_q) * mtc_pkg::MAX_SUCCESSORS);
	assign succ_raddr = succ_base + mtc_pkg::SA_W'(sidx_q[mtc_pkg::SLOT_W-1:0]);
	assign succ_hit   = spend_q &&
		(succ_rdata[mtc_pkg::COUNT_BITS +: mtc_pkg::POS_W] == pos_q);
	assign succ_miss  = !spend_q && (sidx_q == stot_q);
	assign succ_room  = (stot_q < mtc_pkg::SI_W'(mtc_pkg::MAX_SUCCESSORS));

	assign cnt_cur  = succ_rdata[mtc_pkg::COUNT_BITS-1:0];
	assign cnt_sat  = &cnt_cur;
	assign cnt_next = cnt_sat ? cnt_cur : cnt_cur + mtc_pkg::COUNT_BITS'(1);

	always_comb begin
		succ_we    = 1'b0;
		succ_waddr = succ_base + mtc_pkg::SA_W'(spend_idx_q);
		succ_wdata = {pos_q, cnt_next};
		tot_we     = 1'b0;
		if (state_q == ST_SSCAN) begin
			if (succ_hit) begin
				succ_we = 1'b1;
			end else if (succ_miss && succ_room) begin
				succ_we    = 1'b1;
				succ_waddr = succ_base + mtc_pkg::SA_W'(stot_q[mtc_pkg::SLOT_W-1:0]);
				succ_wdata = {pos_q, mtc_pkg::COUNT_BITS'(1)};
				tot_we     = 1'b1;
			end
		end
	end

	mtc_ram #(
		.WIDTH (mtc_pkg::KEY_W),
		.DEPTH (mtc_pkg::MAX_MESSAGES)
	) u_msg_ram (
		.clk   (clk),
		.we    (msg_we),
		.waddr (mtotal_q[mtc_pkg::POS_W-1:0]),
		.wdata (key_q),
		.raddr (idx_q[mtc_pkg::POS_W-1:0]),
		.rdata (msg_rdata)
	);

	mtc_ram #(
		.WIDTH (mtc_pkg::SUCC_W),
		.DEPTH (mtc_pkg::MAX_MESSAGES * mtc_pkg::MAX_SUCCESSORS)
	) u_succ_ram (
		.clk   (clk),
		.we    (succ_we),
		.waddr (succ_waddr),
		.wdata (succ_wdata),
		.raddr (succ_raddr),
		.rdata (succ_rdata)
	);

	// Successor list lengths; an entry whose valid bit is clear is taken as zero.
	mtc_ram #(
		.WIDTH (mtc_pkg::SI_W),
		.DEPTH (mtc_pkg::MAX_MESSAGES)
	) u_tot_ram (
		.clk   (clk),
		.we    (tot_we),
		.waddr (prev_pos_q),
		.wdata (stot_q + mtc_pkg::SI_W'(1)),
		.raddr (prev_pos_q),
		.rdata (tot_rdata)
	);

	assign out_load = (state_q == ST_RESULT) && out_space;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			key_q        <= '0;
			pos_q        <= '0;
			mtotal_q     <= '0;
			prev_valid_q <= 1'b0;
			prev_pos_q   <= '0;
			st_vld_q     <= '0;
			pend_q       <= 1'b0;
			pend_idx_q   <= '0;
			spend_q      <= 1'b0;
			spend_idx_q  <= '0;
			idx_q        <= '0;
			sidx_q       <= '0;
			stot_q       <= '0;
			res_q        <= '0;
		end else begin
			case (state_q)
				ST_IDLE: begin
					if (in_valid) begin
						key_q <= {msg_length, status_byte,
							(msg_length >= 2'd2) ? data_one : 8'd0,
							(msg_length == 2'd3) ? data_two : 8'd0};
						res_q  <= '0;
						idx_q  <= '0;
						pend_q <= 1'b0;
						if (msg_length != 2'd0) begin
							state_q <= ST_MSCAN;
						end
					end
				end
				ST_MSCAN: begin
					if (msg_hit) begin
						pos_q          <= pend_idx_q;
						res_q.position <= pend_idx_q;
						state_q        <= prev_valid_q ? ST_TOTRD : ST_RESULT;
					end else if (msg_miss) begin
						if (msg_tab_full) begin
							res_q.table_full <= 1'b1;
							prev_valid_q     <= 1'b0;
							state_q          <= ST_RESULT;
						end else begin
							pos_q                 <= mtotal_q[mtc_pkg::POS_W-1:0];
							res_q.position        <= mtotal_q[mtc_pkg::POS_W-1:0];
							res_q.position_is_new <= 1'b1;
							mtotal_q              <= mtotal_q + mtc_pkg::MT_W'(1);
							state_q               <= prev_valid_q ? ST_TOTRD : ST_RESULT;
						end
					end else if (idx_q != mtotal_q) begin
						idx_q      <= idx_q + mtc_pkg::MT_W'(1);
						pend_q     <= 1'b1;
						pend_idx_q <= idx_q[mtc_pkg::POS_W-1:0];
					end else begin
						pend_q <= 1'b0;
					end
				end
				ST_TOTRD: begin
					state_q <= ST_TOTCHK;
				end
				ST_TOTCHK: begin
					stot_q  <= st_vld_q[prev_pos_q] ? tot_rdata : '0;
					sidx_q  <= '0;
					spend_q <= 1'b0;
					state_q <= ST_SSCAN;
				end
				ST_SSCAN: begin
					if (succ_hit) begin
						res_q.had_previous     <= 1'b1;
						res_q.successor_slot   <= spend_idx_q;
						res_q.transition_count <= cnt_next;
						res_q.count_saturated  <= cnt_sat;
						state_q                <= ST_RESULT;
					end else if (succ_miss) begin
						if (succ_room) begin
							res_q.had_previous     <= 1'b1;
							res_q.successor_slot   <= stot_q[mtc_pkg::SLOT_W-1:0];
							res_q.successor_is_new <= 1'b1;
							res_q.transition_count <= mtc_pkg::COUNT_BITS'(1);
							st_vld_q[prev_pos_q]   <= 1'b1;
						end else begin
							res_q.successors_full <= 1'b1;
						end
						state_q <= ST_RESULT;
					end else if (sidx_q != stot_q) begin
						sidx_q      <= sidx_q + mtc_pkg::SI_W'(1);
						spend_q     <= 1'b1;
						spend_idx_q <= sidx_q[mtc_pkg::SLOT_W-1:0];
					end else begin
						spend_q <= 1'b0;
					end
				end
				ST_RESULT: begin
					// The message becomes the previous one unless it was dropped.
					if (!res_q.table_full) begin
						prev_valid_q <= 1'b1;
						prev_pos_q   <= pos_q;
					end
					if (out_space) begin
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	mtc_out_reg u_out_reg (
		.clk       (clk),
		.arst_n    (arst_n),
		.load      (out_load),
		.res_in    (res_q),
		.space     (out_space),
		.out_ready (out_ready),
		.out_valid (out_valid),
		.res_out   (res_out)
	);

	assign position         = 8'(res_out.position);
	assign position_is_new  = res_out.position_is_new;
	assign had_previous     = res_out.had_previous;
	assign successor_slot   = 4'(res_out.successor_slot);
	assign successor_is_new = res_out.successor_is_new;
	assign transition_count = 16'(res_out.transition_count);
	assign table_full       = res_out.table_full;
	assign successors_full  = res_out.successors_full;
	assign count_saturated  = res_out.count_saturated;

endmodule

@@ sv/mtc_ram.sv @@
module mtc_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 256
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

@@ sv/mtc_out_reg.sv @@
module mtc_out_reg (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             load,
	input  mtc_pkg::result_t res_in,
	output logic             space,
	input  logic             out_ready,
	output logic             out_valid,
	output mtc_pkg::result_t res_out
);

	logic             valid_q;
	mtc_pkg::result_t res_q;

	// The register can take a new beat when it is empty or being drained.
	assign space     = !valid_q || out_ready;
	assign out_valid = valid_q;
	assign res_out   = res_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_q <= 1'b0;
		end else if (load) begin
			valid_q <= 1'b1;
		end else if (out_ready) begin
			valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load) begin
			res_q <= res_in;
		end
	end

endmodule
